@@ rtl/u64da_pkg.sv @@
// ----------------------------------------------------------------------------
// u64da_pkg
// Types and constants shared by the 64-bit to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u64da_pkg;

   localparam int ValueWidth = 64;
   localparam int NumDigits  = 20;
   localparam int DigitWidth = 4;
   localparam int BcdWidth   = NumDigits * DigitWidth;
   localparam int CharWidth  = 8;
   localparam int RspWidth   = NumDigits * CharWidth;

   localparam logic [DigitWidth-1:0] AdjustLimit = 4'd5;
   localparam logic [DigitWidth-1:0] AdjustAdd   = 4'd3;
   localparam logic [CharWidth-1:0]  AsciiZero   = 8'h30;

   // Work word carried down the cell row: binary bits still to shift in,
   // and the BCD digits built so far (digit 0 in the top nibble).
   typedef struct packed {
      logic [ValueWidth-1:0] bin;
      logic [BcdWidth-1:0]   bcd;
   } conv_type;

endpackage

@@ rtl/u64da_cell.sv @@
// ----------------------------------------------------------------------------
// u64da_cell
// One shift-and-add-3 step: adjust every BCD digit, then shift in one bit.
// ----------------------------------------------------------------------------
module u64da_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  u64da_pkg::conv_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output u64da_pkg::conv_type dn_data
);
   import u64da_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   conv_type data_ff;
   conv_type data_in;
   logic [BcdWidth-1:0] bcd_adj;

   // Accept when empty or when the held item moves on this cycle.
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      for (int d = 0; d < NumDigits; d++) begin
         if (up_data.bcd[d*DigitWidth +: DigitWidth] >= AdjustLimit) begin
            bcd_adj[d*DigitWidth +: DigitWidth] =
               up_data.bcd[d*DigitWidth +: DigitWidth] + AdjustAdd;
         end else begin
            bcd_adj[d*DigitWidth +: DigitWidth] =
               up_data.bcd[d*DigitWidth +: DigitWidth];
         end
      end
      data_in.bcd = {bcd_adj[BcdWidth-2:0], up_data.bin[ValueWidth-1]};
      data_in.bin = {up_data.bin[ValueWidth-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ rtl/u64da_ascii.sv @@
// ----------------------------------------------------------------------------
// u64da_ascii
// Output register: turns the finished BCD digits into packed ASCII.
// ----------------------------------------------------------------------------
module u64da_ascii (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  u64da_pkg::conv_type           up_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [u64da_pkg::RspWidth-1:0] rsp_tdata
);
   import u64da_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [RspWidth-1:0] tdata_ff;
   logic [RspWidth-1:0] tdata_in;
   logic [BcdWidth-1:0] chars_be;

   assign up_ready = !valid_ff || rsp_tready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // Digit 0 sits in the top nibble of bcd; map nibble to byte in place.
   // Fields from the low end, each top byte first, hold digits 0..7, 8..15, 16..19.
   always_comb begin
      chars_be = up_data.bcd;
      for (int d = 0; d < 8; d++) begin
         tdata_in[d*CharWidth +: CharWidth] =
            AsciiZero | {4'd0, chars_be[(12 + d)*DigitWidth +: DigitWidth]};
         tdata_in[64 + d*CharWidth +: CharWidth] =
            AsciiZero | {4'd0, chars_be[(4 + d)*DigitWidth +: DigitWidth]};
      end
      for (int d = 0; d < 4; d++) begin
         tdata_in[128 + d*CharWidth +: CharWidth] =
            AsciiZero | {4'd0, chars_be[d*DigitWidth +: DigitWidth]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         tdata_ff <= tdata_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;

endmodule

@@ rtl/uint64_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// uint64_to_decimal_ascii_top
// Unsigned 64-bit value to 20 ASCII decimal digits, leading zeros kept.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  req_     in    64    value
//  rsp_     out  160    chars_first_eight, chars_middle_eight, chars_last_four
//
//  One item per cycle sustained while rsp_tready is high. A row of 64
//  shift-and-add-3 cells, one per input bit, feeds the ASCII output register.
//  Each cell holds one item and moves it on when its neighbor has room, so
//  empty cells keep filling while the output waits on rsp_tready.
//  Synchronous reset empties every cell and the output register.
// ----------------------------------------------------------------------------
module uint64_to_decimal_ascii_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [u64da_pkg::ValueWidth-1:0] req_tdata,  // [63:0] value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [63:0] chars_first_eight, [127:64] chars_middle_eight,
   // [159:128] chars_last_four
   output logic [u64da_pkg::RspWidth-1:0]   rsp_tdata
);
   import u64da_pkg::*;

   localparam int NumCells = ValueWidth;

   logic     link_valid [NumCells+1];
   logic     link_ready [NumCells+1];
   conv_type link_data  [NumCells+1];

   assign link_valid[0]    = req_tvalid;
   assign req_tready       = link_ready[0];
   assign link_data[0].bin = req_tdata;
   assign link_data[0].bcd = '0;

   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      u64da_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[c]),
         .up_ready (link_ready[c]),
         .up_data  (link_data[c]),
         .dn_valid (link_valid[c+1]),
         .dn_ready (link_ready[c+1]),
         .dn_data  (link_data[c+1])
      );
   end

   u64da_ascii u_ascii (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (link_valid[NumCells]),
      .up_ready   (link_ready[NumCells]),
      .up_data    (link_data[NumCells]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/u64da_checker.sv @@
// ----------------------------------------------------------------------------
// u64da_checker
// Port-level checks for the decimal ASCII converter.
// ----------------------------------------------------------------------------
module u64da_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [u64da_pkg::ValueWidth-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [u64da_pkg::RspWidth-1:0]   rsp_tdata
);
   import u64da_pkg::*;

   function automatic logic all_digits(input logic [RspWidth-1:0] word);
      logic ok;
      ok = 1'b1;
      for (int b = 0; b < NumDigits; b++) begin
         if (word[b*CharWidth+4 +: 4] != AsciiZero[7:4]) ok = 1'b0;
         if (word[b*CharWidth +: 4] > 4'd9) ok = 1'b0;
      end
      return ok;
   endfunction

   // Hold a waiting input item until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting input item changed");

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Drop everything on reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Every byte is a decimal digit character.
   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> all_digits(rsp_tdata))
      else $error("non-digit character in result");

   // A 64-bit value never exceeds 1.9e19, so the top digit is 0 or 1.
   a_top_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:56] == 8'h30 || rsp_tdata[63:56] == 8'h31))
      else $error("top digit out of range");

endmodule

bind uint64_to_decimal_ascii_top u64da_checker u_u64da_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
